// ===== src/ring_neighbor_resource_arbiter_unit_assert.svh =====
// Assertion macros for the ring neighbor resource arbiter checker.
`ifndef RING_NEIGHBOR_RESOURCE_ARBITER_UNIT_ASSERT_SVH
`define RING_NEIGHBOR_RESOURCE_ARBITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RNRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rnra assertion failed");

// Next-cycle implication, checked outside reset.
`define RNRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rnra assertion failed");

`endif

// ===== src/rnra_pkg.sv =====
// Shared types, constants and neighbor functions of the ring arbiter.
package rnra_pkg;

    localparam int MAX_SEATS   = 8;
    localparam int SEAT_IDX_W  = $clog2(MAX_SEATS);
    localparam int SEAT_CNT_W  = 4;
    localparam int MASK_W      = 8;

    localparam logic [SEAT_CNT_W-1:0] SEAT_CNT_RESET = 4'd5;
    localparam logic [SEAT_CNT_W-1:0] SEAT_CNT_MIN   = 4'd2;
    localparam logic [SEAT_CNT_W-1:0] SEAT_CNT_MAX   = SEAT_CNT_W'(MAX_SEATS);

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef logic [SEAT_IDX_W-1:0] t_seat_idx;
    typedef logic [SEAT_CNT_W-1:0] t_seat_cnt;

    typedef enum logic [1:0] {
        SEAT_IDLE = 2'd0,
        SEAT_WAIT = 2'd1,
        SEAT_HOLD = 2'd2
    } t_seat_st;

    typedef t_seat_st [MAX_SEATS-1:0] t_seat_vec;

    typedef struct packed {
        logic exec;
    } t_dp_cmd;

    // Effective ring size: the register clamped into the legal range.
    function automatic t_seat_cnt f_ring_size(input t_seat_cnt cnt);
        t_seat_cnt res;
        res = cnt;
        if (cnt < SEAT_CNT_MIN) res = SEAT_CNT_MIN;
        if (cnt > SEAT_CNT_MAX) res = SEAT_CNT_MAX;
        return res;
    endfunction

    function automatic t_seat_idx f_left(input t_seat_idx i, input t_seat_cnt n);
        t_seat_cnt last;
        last = n - 4'd1;
        return (i == '0) ? last[SEAT_IDX_W-1:0] : t_seat_idx'(i - 1'b1);
    endfunction

    function automatic t_seat_idx f_right(input t_seat_idx i, input t_seat_cnt n);
        t_seat_cnt nxt;
        nxt = t_seat_cnt'(i) + 4'd1;
        return (nxt == n) ? '0 : nxt[SEAT_IDX_W-1:0];
    endfunction

endpackage

// ===== src/rnra_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface rnra_req_if;
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [2:0]              seat_index;

    modport source (output valid, output func, output seat_index, input ready);
    modport sink   (input valid, input func, input seat_index, output ready);
endinterface

interface rnra_rsp_if;
    logic                    valid;
    logic                    ready;
    logic [7:0]              new_grants;
    logic [7:0]              holding_mask;
    logic                    bad_index;

    modport source (output valid, output new_grants, output holding_mask,
                    output bad_index, input ready);
    modport sink   (input valid, input new_grants, input holding_mask,
                    input bad_index, output ready);
endinterface

// ===== src/rnra_ctrl.sv =====
// Controller: sequences one request at a time from acceptance to delivery.
module rnra_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output rnra_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state     <= ST_SEND;
                        r_in_ready  <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                end
                ST_SEND: begin
                    if (i_out_ready) begin
                        r_state     <= ST_IDLE;
                        r_in_ready  <= 1'b1;
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    // The datapath evaluates and registers the result in the accept cycle.
    assign o_cmd.exec  = i_in_valid && r_in_ready;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/rnra_dp.sv =====
// Datapath: seat state table, ring size register and result register.
module rnra_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rnra_pkg::t_dp_cmd                   i_cmd,
    input  logic                                i_func,
    input  rnra_pkg::t_seat_idx                 i_seat_index,
    input  logic                                i_cfg_we,
    input  rnra_pkg::t_seat_cnt                 i_cfg_wdata,
    output logic [rnra_pkg::MASK_W-1:0]         o_new_grants,
    output logic [rnra_pkg::MASK_W-1:0]         o_holding_mask,
    output logic                                o_bad_index
);

    rnra_pkg::t_seat_vec                 r_seat;
    rnra_pkg::t_seat_cnt                 r_seat_count;
    logic [rnra_pkg::MASK_W-1:0]         r_new_grants;
    logic [rnra_pkg::MASK_W-1:0]         r_holding;
    logic                                r_bad;

    rnra_pkg::t_seat_vec                 n_seat;
    logic [rnra_pkg::MASK_W-1:0]         n_grants;
    logic [rnra_pkg::MASK_W-1:0]         n_holding;
    logic                                n_bad;
    rnra_pkg::t_seat_cnt                 ring_n;
    rnra_pkg::t_seat_cnt                 cfg_n;
    rnra_pkg::t_seat_idx                 seat_l;
    rnra_pkg::t_seat_idx                 seat_r;

    // A waiting seat is granted when neither of its neighbors holds.
    function automatic logic f_can_grant(input rnra_pkg::t_seat_vec st,
                                         input rnra_pkg::t_seat_idx i,
                                         input rnra_pkg::t_seat_cnt n);
        return (st[i] == rnra_pkg::SEAT_WAIT) &&
               (st[rnra_pkg::f_left(i, n)] != rnra_pkg::SEAT_HOLD) &&
               (st[rnra_pkg::f_right(i, n)] != rnra_pkg::SEAT_HOLD);
    endfunction

    assign ring_n = rnra_pkg::f_ring_size(r_seat_count);
    assign cfg_n  = rnra_pkg::f_ring_size(i_cfg_wdata);
    assign seat_l = rnra_pkg::f_left(i_seat_index, ring_n);
    assign seat_r = rnra_pkg::f_right(i_seat_index, ring_n);
    assign n_bad  = (rnra_pkg::t_seat_cnt'(i_seat_index) >= ring_n);

    always_comb begin
        n_seat   = r_seat;
        n_grants = '0;
        if (!n_bad) begin
            if (i_func == rnra_pkg::FUNC_REQUEST) begin
                n_seat[i_seat_index] = rnra_pkg::SEAT_WAIT;
                if (f_can_grant(n_seat, i_seat_index, ring_n)) begin
                    n_seat[i_seat_index]   = rnra_pkg::SEAT_HOLD;
                    n_grants[i_seat_index] = 1'b1;
                end
            end else begin
                n_seat[i_seat_index] = rnra_pkg::SEAT_IDLE;
                if (f_can_grant(n_seat, seat_l, ring_n)) begin
                    n_seat[seat_l]   = rnra_pkg::SEAT_HOLD;
                    n_grants[seat_l] = 1'b1;
                end
                // In a ring of two this finds the left grant and does nothing.
                if (f_can_grant(n_seat, seat_r, ring_n)) begin
                    n_seat[seat_r]   = rnra_pkg::SEAT_HOLD;
                    n_grants[seat_r] = 1'b1;
                end
            end
        end
        for (int i = 0; i < rnra_pkg::MASK_W; i++) begin
            n_holding[i] = (n_seat[i] == rnra_pkg::SEAT_HOLD) &&
                           (rnra_pkg::t_seat_cnt'(i) < ring_n);
        end
    end

    // The user must write the ring size only while no request is in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rnra_pkg::MAX_SEATS; i++) begin
                r_seat[i] <= rnra_pkg::SEAT_IDLE;
            end
            r_seat_count <= rnra_pkg::SEAT_CNT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_seat_count <= i_cfg_wdata;
                for (int i = 0; i < rnra_pkg::MAX_SEATS; i++) begin
                    if (rnra_pkg::t_seat_cnt'(i) >= cfg_n) begin
                        r_seat[i] <= rnra_pkg::SEAT_IDLE;
                    end
                end
            end else if (i_cmd.exec) begin
                r_seat <= n_seat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_new_grants <= n_grants;
            r_holding    <= n_holding;
            r_bad        <= n_bad;
        end
    end

    assign o_new_grants   = r_new_grants;
    assign o_holding_mask = r_holding;
    assign o_bad_index    = r_bad;

endmodule

// ===== src/ring_neighbor_resource_arbiter_unit.sv =====
// Top level of the ring neighbor resource arbiter.
//
//  Channel  Dir  Handshake        Payload
//  i_req    in   valid / ready    func, seat_index
//  o_rsp    out  valid / ready    new_grants, holding_mask, bad_index
//  cfg      in   i_cfg_we         i_cfg_wdata (seat_count)
//
// A request is evaluated in the cycle it is accepted and its result is shown
// from the next cycle, held in the single result register until it is taken.
// Reset clears the seat table to all idle and the ring size to five.
// While a result waits, no new request is accepted.
module ring_neighbor_resource_arbiter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rnra_req_if.sink            i_req,
    rnra_rsp_if.source          o_rsp,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_wdata
);

    rnra_pkg::t_dp_cmd cmd;

    rnra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    rnra_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_req.func),
        .i_seat_index   (i_req.seat_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_new_grants   (o_rsp.new_grants),
        .o_holding_mask (o_rsp.holding_mask),
        .o_bad_index    (o_rsp.bad_index)
    );

endmodule

// ===== src/rnra_checker.sv =====
// Port-level assertion checker for the ring arbiter, bound to the top level.
`include "ring_neighbor_resource_arbiter_unit_assert.svh"

module rnra_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_new_grants,
    input logic [7:0] i_holding_mask,
    input logic       i_bad_index
);

    // A seat granted by this request must be among the holders.
    `RNRA_ASSERT_NOW(a_grant_held, i_clk, i_rst_n, i_out_valid, ~|(i_new_grants & ~i_holding_mask))

    // A rejected seat index grants nothing.
    `RNRA_ASSERT_NOW(a_bad_no_grant, i_clk, i_rst_n, i_out_valid & i_bad_index, ~|i_new_grants)

    // Every accepted request shows its result in the next cycle.
    `RNRA_ASSERT_NEXT(a_accept_result, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid)

    // A waiting result stays until it is taken.
    `RNRA_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

endmodule

bind ring_neighbor_resource_arbiter_unit rnra_checker u_rnra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_new_grants   (o_rsp.new_grants),
    .i_holding_mask (o_rsp.holding_mask),
    .i_bad_index    (o_rsp.bad_index)
);
